// ===== src/per_function_call_statistics_table_unit_assert.svh =====
// Assertion macros used by the checker file of the statistics table.
`ifndef PER_FUNCTION_CALL_STATISTICS_TABLE_UNIT_ASSERT_SVH
`define PER_FUNCTION_CALL_STATISTICS_TABLE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFCST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define PFCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pfcst_pkg.sv =====
package pfcst_pkg;

    localparam int FUNC_ID_W = 8;
    localparam int STAMP_W   = 48;
    localparam int COUNT_W   = 48;
    localparam int VALUE_W   = 40;
    localparam int TOTAL_W   = 64;
    localparam int BURST_W   = 32;

    localparam logic [STAMP_W-1:0] WIN_LIMIT_RESET = 48'd3000000000;

    localparam logic OP_TIMED = 1'b0;
    localparam logic OP_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC
    } t_state;

    typedef struct packed {
        logic                 opcode;
        logic [FUNC_ID_W-1:0] func_id;
        logic [STAMP_W-1:0]   now;
        logic [VALUE_W-1:0]   duration;
        logic [VALUE_W-1:0]   size;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] calls;
        logic [STAMP_W-1:0] first_stamp;
        logic [STAMP_W-1:0] last_stamp;
        logic [TOTAL_W-1:0] dur_sum;
        logic [VALUE_W-1:0] dur_min;
        logic [VALUE_W-1:0] dur_max;
        logic [TOTAL_W-1:0] size_sum;
        logic [VALUE_W-1:0] size_min;
        logic [VALUE_W-1:0] size_max;
        logic [STAMP_W-1:0] win_start;
        logic               win_open;
        logic [BURST_W-1:0] win_hits;
        logic [BURST_W-1:0] burst_min;
        logic [BURST_W-1:0] burst_max;
    } t_entry;

    typedef struct packed {
        logic               bad_function;
        logic [COUNT_W-1:0] calls;
        logic [STAMP_W-1:0] first_time;
        logic [STAMP_W-1:0] last_time;
        logic [TOTAL_W-1:0] time_total;
        logic [VALUE_W-1:0] time_least;
        logic [VALUE_W-1:0] time_most;
        logic [TOTAL_W-1:0] size_total;
        logic [VALUE_W-1:0] size_least;
        logic [VALUE_W-1:0] size_most;
        logic [BURST_W-1:0] burst_least;
        logic [BURST_W-1:0] burst_most;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
    } t_sts;

    // A stored zero means empty, so the new value is then always taken.
    function automatic logic [TOTAL_W-1:0] take_min(input logic [TOTAL_W-1:0] cur,
                                                   input logic [TOTAL_W-1:0] v);
        return (cur == '0 || v < cur) ? v : cur;
    endfunction

    function automatic logic [TOTAL_W-1:0] take_max(input logic [TOTAL_W-1:0] cur,
                                                   input logic [TOTAL_W-1:0] v);
        return (cur == '0 || cur < v) ? v : cur;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + (TOTAL_W+1)'(b);
        return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

endpackage

// ===== src/pfcst_item_if.sv =====
interface pfcst_item_if import pfcst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [FUNC_ID_W-1:0] func_id;
    logic [STAMP_W-1:0]   now;
    logic [VALUE_W-1:0]   duration;
    logic [VALUE_W-1:0]   size;

    modport source (output valid, output opcode, output func_id, output now,
                    output duration, output size, input ready);
    modport sink   (input valid, input opcode, input func_id, input now,
                    input duration, input size, output ready);
endinterface

// ===== src/pfcst_result_if.sv =====
interface pfcst_result_if import pfcst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               bad_function;
    logic [COUNT_W-1:0] calls;
    logic [STAMP_W-1:0] first_time;
    logic [STAMP_W-1:0] last_time;
    logic [TOTAL_W-1:0] time_total;
    logic [VALUE_W-1:0] time_least;
    logic [VALUE_W-1:0] time_most;
    logic [TOTAL_W-1:0] size_total;
    logic [VALUE_W-1:0] size_least;
    logic [VALUE_W-1:0] size_most;
    logic [BURST_W-1:0] burst_least;
    logic [BURST_W-1:0] burst_most;

    modport source (output valid, output bad_function, output calls, output first_time,
                    output last_time, output time_total, output time_least,
                    output time_most, output size_total, output size_least,
                    output size_most, output burst_least, output burst_most,
                    input ready);
    modport sink   (input valid, input bad_function, input calls, input first_time,
                    input last_time, input time_total, input time_least,
                    input time_most, input size_total, input size_least,
                    input size_most, input burst_least, input burst_most,
                    output ready);
endinterface

// ===== src/pfcst_ctrl.sv =====
module pfcst_ctrl import pfcst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (i_sts.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
            end
            ST_CALC: begin
                o_cmd.commit = i_sts.slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/pfcst_datapath.sv =====
module pfcst_datapath import pfcst_pkg::*; #(
    parameter int NUM_FUNCS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [STAMP_W-1:0] i_cfg_wdata,
    input  t_item              i_item,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output t_result            o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);

    localparam int IDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;

    t_entry             mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0] r_valid;

    t_item              r_item;
    t_entry             r_rd_raw;
    logic               r_rd_hit;
    logic [STAMP_W-1:0] r_win_limit;
    t_result            r_res;
    logic               r_res_valid;

    logic [IDX_W-1:0]   idx;
    logic               bad;
    t_entry             cur;
    t_entry             n_entry;
    t_result            n_res;
    logic [STAMP_W-1:0] elapsed;
    logic               win_late;

    assign idx = r_item.func_id[IDX_W-1:0];
    assign bad = {1'b0, r_item.func_id} >= (FUNC_ID_W+1)'(NUM_FUNCS);
    assign cur = r_rd_hit ? r_rd_raw : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_limit <= WIN_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_win_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Table storage: one registered read per item, one write per in-range item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_raw <= mem[idx];
        end
        if (i_cmd.commit && !bad) begin
            mem[idx] <= n_entry;
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_cmd.read) begin
                r_rd_hit <= r_valid[idx];
            end
            if (i_cmd.commit && !bad) begin
                r_valid[idx] <= 1'b1;
            end
        end
    end

    assign elapsed  = r_item.now - cur.win_start;
    assign win_late = (r_item.now > cur.win_start) && (elapsed > r_win_limit);

    always_comb begin
        n_entry = cur;
        if (r_item.opcode == OP_TIMED) begin
            if (cur.calls != '1) begin
                n_entry.calls = cur.calls + COUNT_W'(1);
            end
            if (!cur.win_open) begin
                n_entry.win_open  = 1'b1;
                n_entry.win_start = r_item.now;
            end else if (win_late) begin
                n_entry.burst_min = BURST_W'(take_min(TOTAL_W'(cur.burst_min),
                                                      TOTAL_W'(cur.win_hits)));
                n_entry.burst_max = BURST_W'(take_max(TOTAL_W'(cur.burst_max),
                                                      TOTAL_W'(cur.win_hits)));
                n_entry.win_start = r_item.now;
                n_entry.win_hits  = '0;
            end else if (cur.win_hits != '1) begin
                n_entry.win_hits = cur.win_hits + BURST_W'(1);
            end
            if (cur.first_stamp == '0) begin
                n_entry.first_stamp = r_item.now;
            end
            n_entry.last_stamp = r_item.now;
            n_entry.dur_min = VALUE_W'(take_min(TOTAL_W'(cur.dur_min),
                                                TOTAL_W'(r_item.duration)));
            n_entry.dur_max = VALUE_W'(take_max(TOTAL_W'(cur.dur_max),
                                                TOTAL_W'(r_item.duration)));
            n_entry.dur_sum = sat_add(cur.dur_sum, r_item.duration);
        end else begin
            n_entry.size_min = VALUE_W'(take_min(TOTAL_W'(cur.size_min),
                                                 TOTAL_W'(r_item.size)));
            n_entry.size_max = VALUE_W'(take_max(TOTAL_W'(cur.size_max),
                                                 TOTAL_W'(r_item.size)));
            n_entry.size_sum = sat_add(cur.size_sum, r_item.size);
        end
    end

    always_comb begin
        n_res = '0;
        if (bad) begin
            n_res.bad_function = 1'b1;
        end else begin
            n_res.calls       = n_entry.calls;
            n_res.first_time  = n_entry.first_stamp;
            n_res.last_time   = n_entry.last_stamp;
            n_res.time_total  = n_entry.dur_sum;
            n_res.time_least  = n_entry.dur_min;
            n_res.time_most   = n_entry.dur_max;
            n_res.size_total  = n_entry.size_sum;
            n_res.size_least  = n_entry.size_min;
            n_res.size_most   = n_entry.size_max;
            n_res.burst_least = n_entry.burst_min;
            n_res.burst_most  = n_entry.burst_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_sts.slot_free = !r_res_valid || i_res_ready;
    assign o_res           = r_res;
    assign o_res_valid     = r_res_valid;

endmodule

// ===== src/per_function_call_statistics_table_unit.sv =====
// Per-function call statistics table.
// Items arrive on the i_item channel (valid/ready); each is a timed call hit or a size hit
// for one function number, and a transfer completes when valid and ready are both high.
// Each item gives exactly one result on the o_result channel: the updated statistics entry,
// or bad_function set with all other fields zero when func_id is not below NUM_FUNCS.
// The burst window register is written through i_cfg_we / i_cfg_wdata; the user must write
// it only while idle, since the block itself does not enforce that.
// An item passes through capture, table read, and update with write-back, in that order,
// as the entry is read and rewritten through the table's single registered read port, so
// a new item is taken only after the last update; the result is registered at the update.
// A finished result waits in an output register, so the next item is taken and read while
// the receiver stalls; its update holds until the output register is free.
// Reset clears every entry at once through per-entry valid bits, so no clearing pass is
// needed, and sets the burst window to 3000000000 ticks.
module per_function_call_statistics_table_unit import pfcst_pkg::*; #(
    parameter int NUM_FUNCS = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [STAMP_W-1:0]    i_cfg_wdata,
    pfcst_item_if.sink            i_item,
    pfcst_result_if.source        o_result
);

    t_cmd    cmd;
    t_sts    sts;
    t_item   item;
    t_result res;
    logic    res_valid;

    // Pack the incoming payload; it is captured only on an accepted transfer.
    assign item.opcode   = i_item.opcode;
    assign item.func_id  = i_item.func_id;
    assign item.now      = i_item.now;
    assign item.duration = i_item.duration;
    assign item.size     = i_item.size;

    // The controller sequences one item at a time through the datapath.
    pfcst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the table, the burst window register and the output register.
    pfcst_datapath #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_result.ready)
    );

    assign o_result.valid        = res_valid;
    assign o_result.bad_function = res.bad_function;
    assign o_result.calls        = res.calls;
    assign o_result.first_time   = res.first_time;
    assign o_result.last_time    = res.last_time;
    assign o_result.time_total   = res.time_total;
    assign o_result.time_least   = res.time_least;
    assign o_result.time_most    = res.time_most;
    assign o_result.size_total   = res.size_total;
    assign o_result.size_least   = res.size_least;
    assign o_result.size_most    = res.size_most;
    assign o_result.burst_least  = res.burst_least;
    assign o_result.burst_most   = res.burst_most;

endmodule

// ===== src/pfcst_checker.sv =====
`include "per_function_call_statistics_table_unit_assert.svh"

module pfcst_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfcst_item_if.sink     i_item,
    pfcst_result_if.source o_result
);

    // A stalled result keeps its payload.
    `PFCST_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_result.valid && !o_result.ready, o_result.valid && $stable(o_result.calls) && $stable(o_result.time_total) && $stable(o_result.size_total), "result changed while stalled")

    // An accepted item blocks the input for its read and update cycles.
    `PFCST_ASSERT_NEXT(a_item_spacing, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready ##1 !i_item.ready, "input taken before the previous update")

    // A bad function number gives an otherwise empty result.
    `PFCST_ASSERT_SAME(a_bad_empty, i_clk, i_rst_n, o_result.valid && o_result.bad_function, o_result.calls == '0 && o_result.time_total == '0 && o_result.size_total == '0 && o_result.burst_most == '0, "bad function result not empty")

    // Minimum never exceeds maximum in any tracked quantity.
    `PFCST_ASSERT_SAME(a_least_most, i_clk, i_rst_n, o_result.valid && !o_result.bad_function, o_result.time_least <= o_result.time_most && o_result.size_least <= o_result.size_most && o_result.burst_least <= o_result.burst_most, "minimum above maximum")

endmodule

bind per_function_call_statistics_table_unit pfcst_checker u_pfcst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_item   (i_item),
    .o_result (o_result)
);

// ===== dv/tb_per_function_call_statistics_table_unit.sv =====
`timescale 1ns / 100ps

module tb_per_function_call_statistics_table_unit import pfcst_pkg::*; ();

    localparam int FUNC_COUNT    = 128;
    // Cycles without any transfer before the run is abandoned. The longest
    // legitimate quiet spell is the receiver hold-off below, plus sender gaps.
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 320;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // Mirror of the statistics table. Every accepted item is applied to the
    // mirror at once, and the entry it produces is queued for comparison, in
    // order, with the result transfers.
    class call_stats_book;
        t_entry             entries[FUNC_COUNT];
        logic [STAMP_W-1:0] win_limit;
        t_result            awaited_entries[$];
        int                 mismatches;
        int                 results_checked;
        int                 timed_hits;
        int                 size_hits;
        int                 bad_hits;
        int                 closed_windows;

        function new();
            foreach (entries[i]) entries[i] = '0;
            win_limit       = WIN_LIMIT_RESET;
            mismatches      = 0;
            results_checked = 0;
            timed_hits      = 0;
            size_hits       = 0;
            bad_hits        = 0;
            closed_windows  = 0;
        endfunction

        function logic [TOTAL_W-1:0] saturating_total(logic [TOTAL_W-1:0] acc,
                                                      logic [VALUE_W-1:0] add);
            logic [TOTAL_W-1:0] s;
            s = acc + TOTAL_W'(add);
            return (s < acc) ? '1 : s;
        endfunction

        function void log_accepted_item(t_item it);
            t_result r;
            t_entry  e;
            r = '0;
            // Out-of-range function numbers leave the table alone and return
            // an all-zero entry with only the error flag set.
            if (int'(it.func_id) >= FUNC_COUNT) begin
                r.bad_function = 1'b1;
                bad_hits++;
                awaited_entries.push_back(r);
                return;
            end
            e = entries[it.func_id];
            if (it.opcode == OP_TIMED) begin
                timed_hits++;
                if (e.calls != '1) e.calls = e.calls + COUNT_W'(1);
                if (!e.win_open) begin
                    // The very first timed hit only opens the window.
                    e.win_open  = 1'b1;
                    e.win_start = it.now;
                end else if (it.now > e.win_start &&
                             it.now - e.win_start > win_limit) begin
                    if (e.burst_min == '0 || e.win_hits < e.burst_min)
                        e.burst_min = e.win_hits;
                    if (e.win_hits > e.burst_max) e.burst_max = e.win_hits;
                    e.win_start = it.now;
                    e.win_hits  = '0;
                    closed_windows++;
                end else if (e.win_hits != '1) begin
                    e.win_hits = e.win_hits + BURST_W'(1);
                end
                if (e.first_stamp == '0) e.first_stamp = it.now;
                e.last_stamp = it.now;
                // A stored zero minimum is empty and always replaced.
                if (e.dur_min == '0 || it.duration < e.dur_min) e.dur_min = it.duration;
                if (it.duration > e.dur_max) e.dur_max = it.duration;
                e.dur_sum = saturating_total(e.dur_sum, it.duration);
            end else begin
                size_hits++;
                if (e.size_min == '0 || it.size < e.size_min) e.size_min = it.size;
                if (it.size > e.size_max) e.size_max = it.size;
                e.size_sum = saturating_total(e.size_sum, it.size);
            end
            entries[it.func_id] = e;
            r.calls       = e.calls;
            r.first_time  = e.first_stamp;
            r.last_time   = e.last_stamp;
            r.time_total  = e.dur_sum;
            r.time_least  = e.dur_min;
            r.time_most   = e.dur_max;
            r.size_total  = e.size_sum;
            r.size_least  = e.size_min;
            r.size_most   = e.size_max;
            r.burst_least = e.burst_min;
            r.burst_most  = e.burst_max;
            awaited_entries.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: field %s differs, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_returned_entry(t_result got);
            t_result want;
            if (awaited_entries.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transfer with no entry awaited, calls %0h",
                             $time, got.calls);
                return;
            end
            want = awaited_entries.pop_front();
            results_checked++;
            compare_field("bad_function", 64'(want.bad_function), 64'(got.bad_function));
            compare_field("calls",        64'(want.calls),        64'(got.calls));
            compare_field("first_time",   64'(want.first_time),   64'(got.first_time));
            compare_field("last_time",    64'(want.last_time),    64'(got.last_time));
            compare_field("time_total",   want.time_total,        got.time_total);
            compare_field("time_least",   64'(want.time_least),   64'(got.time_least));
            compare_field("time_most",    64'(want.time_most),    64'(got.time_most));
            compare_field("size_total",   want.size_total,        got.size_total);
            compare_field("size_least",   64'(want.size_least),   64'(got.size_least));
            compare_field("size_most",    64'(want.size_most),    64'(got.size_most));
            compare_field("burst_least",  64'(want.burst_least),  64'(got.burst_least));
            compare_field("burst_most",   64'(want.burst_most),   64'(got.burst_most));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [STAMP_W-1:0] cfg_wdata;

    pfcst_item_if   item_if();
    pfcst_result_if result_if();

    call_stats_book book = new();

    // Per-function timestamp that the well-formed random traffic advances,
    // so that burst windows open, fill up and close as in real use.
    logic [STAMP_W-1:0] stamp_track[FUNC_COUNT];
    int                 items_accepted = 0;
    int                 idle_cycles    = 0;
    int                 windows_set    = 1;

    per_function_call_statistics_table_unit #(
        .NUM_FUNCS (FUNC_COUNT)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #1 clk = ~clk;

    // Both channels are sampled at the rising edge, where every testbench
    // input still holds its value from the previous edge. The watchdog
    // counts edges on which neither channel completes a transfer.
    always @(posedge clk) begin : transfer_monitor
        t_item   seen;
        t_result got;
        if (rst_n) begin
            if (item_if.valid && item_if.ready) begin
                seen.opcode   = item_if.opcode;
                seen.func_id  = item_if.func_id;
                seen.now      = item_if.now;
                seen.duration = item_if.duration;
                seen.size     = item_if.size;
                book.log_accepted_item(seen);
                items_accepted++;
            end
            if (result_if.valid && result_if.ready) begin
                got.bad_function = result_if.bad_function;
                got.calls        = result_if.calls;
                got.first_time   = result_if.first_time;
                got.last_time    = result_if.last_time;
                got.time_total   = result_if.time_total;
                got.time_least   = result_if.time_least;
                got.time_most    = result_if.time_most;
                got.size_total   = result_if.size_total;
                got.size_least   = result_if.size_least;
                got.size_most    = result_if.size_most;
                got.burst_least  = result_if.burst_least;
                got.burst_most   = result_if.burst_most;
                book.check_returned_entry(got);
            end
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver pacing: full or near-full acceptance, coin-flip stalls and a
    // one-in-three pattern. Once, early in the run, it holds off for a long
    // stretch while the sender keeps offering, so the block backs up fully.
    initial begin : result_pacing
        int seg_left;
        int style;
        bit held_off;
        seg_left = 0;
        style    = 0;
        held_off = 1'b0;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && items_accepted >= HOLD_AFTER) begin
                held_off = 1'b1;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0) begin
                style    = $urandom_range(0, 3);
                seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (style)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= 1'($urandom_range(0, 1));
                2: result_if.ready <= (seg_left % 3 == 0);
                default: result_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clk);
        end
    end

    function automatic t_item mk_item(logic op, logic [FUNC_ID_W-1:0] f,
                                      logic [STAMP_W-1:0] t, logic [VALUE_W-1:0] d,
                                      logic [VALUE_W-1:0] s);
        t_item it;
        it.opcode   = op;
        it.func_id  = f;
        it.now      = t;
        it.duration = d;
        it.size     = s;
        return it;
    endfunction

    // Durations and sizes lean towards zero, the maximum and small values,
    // since those are where the empty-minimum rule and the totals bite.
    function automatic logic [VALUE_W-1:0] pick_amount();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return VALUE_W'($urandom_range(1, 64));
            default: return raw[VALUE_W-1:0];
        endcase
    endfunction

    function automatic t_item make_item(logic [STAMP_W-1:0] window);
        t_item       it;
        int          pick;
        int          f;
        logic [63:0] raw;
        logic [63:0] span;
        logic [63:0] step;
        raw         = {$urandom, $urandom};
        it.opcode   = ($urandom_range(0, 9) < 7) ? OP_TIMED : OP_SIZE;
        it.duration = pick_amount();
        it.size     = pick_amount();
        pick        = $urandom_range(0, 19);
        if (pick < 2) begin
            it.func_id = FUNC_ID_W'($urandom_range(FUNC_COUNT, 255));
            it.now     = raw[STAMP_W-1:0];
        end else if (pick < 4) begin
            // Noise: any function number and an arbitrary timestamp.
            it.func_id = FUNC_ID_W'($urandom_range(0, 255));
            it.now     = raw[STAMP_W-1:0];
        end else begin
            // Well-formed traffic: mostly a handful of busy functions, whose
            // clocks move forward by steps inside the window, or beyond it.
            f    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FUNC_COUNT - 1)
                                               : $urandom_range(0, 11);
            span = {16'd0, window};
            case ($urandom_range(0, 9))
                0: step = '0;
                1, 2: step = span + 64'd1 + (raw % (span + 64'd1));
                default: step = raw % (span / 64'd2 + 64'd1);
            endcase
            stamp_track[f] = stamp_track[f] + step[STAMP_W-1:0];
            it.func_id     = FUNC_ID_W'(f);
            it.now         = stamp_track[f];
        end
        return it;
    endfunction

    // Offers the items in bursts of random length, with random gaps between
    // bursts. Valid stays high across back-to-back items, and drops at the
    // end of the batch.
    task automatic transmit(input t_item batch[$]);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        foreach (batch[k]) begin
            item_if.valid    <= 1'b1;
            item_if.opcode   <= batch[k].opcode;
            item_if.func_id  <= batch[k].func_id;
            item_if.now      <= batch[k].now;
            item_if.duration <= batch[k].duration;
            item_if.size     <= batch[k].size;
            @(posedge clk);
            while (!item_if.ready) @(posedge clk);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    item_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        item_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(input int n);
        t_item batch[$];
        repeat (n) batch.push_back(make_item(book.win_limit));
        transmit(batch);
    endtask

    // The window register is only rewritten once every result is back and
    // the pipeline has had a few cycles to go quiet.
    task automatic set_win_limit(input logic [STAMP_W-1:0] ticks);
        while (book.awaited_entries.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        book.win_limit = ticks;
        windows_set++;
    endtask

    task automatic run_directed();
        t_item d[$];
        // Opening hit with a zero duration, which leaves the minimum empty.
        d.push_back(mk_item(OP_TIMED, 8'd0, 48'd100, '0, '0));
        // Timestamp before the window start counts inside; the zero minimum
        // is still empty and takes the new duration.
        d.push_back(mk_item(OP_TIMED, 8'd0, 48'd50, 40'd5, VALUE_MAX));
        // Exactly one window after the start is still inside.
        d.push_back(mk_item(OP_TIMED, 8'd0, WIN_LIMIT_RESET + 48'd100, VALUE_MAX, '0));
        // One tick further closes the window and folds the count.
        d.push_back(mk_item(OP_TIMED, 8'd0, WIN_LIMIT_RESET + 48'd101, 40'd1, '0));
        d.push_back(mk_item(OP_TIMED, 8'd0, WIN_LIMIT_RESET + 48'd102, 40'd3, '0));
        d.push_back(mk_item(OP_SIZE, 8'd0, STAMP_MAX, VALUE_MAX, '0));
        d.push_back(mk_item(OP_SIZE, 8'd0, '0, '0, VALUE_MAX));
        d.push_back(mk_item(OP_SIZE, 8'd0, '0, '0, 40'd7));
        // Out-of-range function numbers, including the top code.
        d.push_back(mk_item(OP_TIMED, 8'd128, 48'd1234, 40'd99, 40'd99));
        d.push_back(mk_item(OP_SIZE, 8'd255, STAMP_MAX, VALUE_MAX, VALUE_MAX));
        // Last valid entry at the top of the timestamp range, then time zero.
        d.push_back(mk_item(OP_TIMED, 8'd127, STAMP_MAX, VALUE_MAX, '0));
        d.push_back(mk_item(OP_TIMED, 8'd127, '0, 40'd1, '0));
        d.push_back(mk_item(OP_SIZE, 8'd127, '0, '0, 40'd1));
        // A first call at time zero leaves the first timestamp empty.
        d.push_back(mk_item(OP_TIMED, 8'd1, '0, 40'd8, '0));
        d.push_back(mk_item(OP_TIMED, 8'd1, 48'd10, 40'd2, '0));
        // Size hit on an entry that has never seen a call.
        d.push_back(mk_item(OP_SIZE, 8'd2, '0, '0, 40'd1000));
        // Closing a one-hit window, with a zero duration that empties the minimum.
        d.push_back(mk_item(OP_TIMED, 8'd0, 48'd9000000000, '0, '0));
        d.push_back(mk_item(OP_TIMED, 8'd0, 48'd9000000005, 40'd6, '0));
        transmit(d);
    endtask

    initial begin : stimulus
        foreach (stamp_track[i]) stamp_track[i] = '0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        item_if.valid    <= 1'b0;
        item_if.opcode   <= OP_TIMED;
        item_if.func_id  <= '0;
        item_if.now      <= '0;
        item_if.duration <= '0;
        item_if.size     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of the window first, then a one-tick and the widest
        // settings, then an arbitrary moderate one.
        run_directed();
        run_random(PHASE_ITEMS);
        set_win_limit(48'd1);
        run_random(PHASE_ITEMS);
        set_win_limit(STAMP_MAX);
        run_random(PHASE_ITEMS);
        set_win_limit(STAMP_W'($urandom_range(2, 100000)));
        run_random(PHASE_ITEMS);

        while (book.awaited_entries.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d timed hits, %0d size hits and %0d out-of-range numbers.",
                 book.timed_hits, book.size_hits, book.bad_hits);
        $display("%0d burst windows closed over %0d window settings; %0d entries compared.",
                 book.closed_windows, windows_set, book.results_checked);
        if (book.mismatches + book.awaited_entries.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pfcst_pkg.sv
src/pfcst_item_if.sv
src/pfcst_result_if.sv
src/pfcst_ctrl.sv
src/pfcst_datapath.sv
src/per_function_call_statistics_table_unit.sv
src/pfcst_checker.sv
dv/tb_per_function_call_statistics_table_unit.sv
